// ===== design/umhp_pkg.sv =====
// ----------------------------------------------------------------------------
// umhp_pkg
// Shared types and constants for the udp message header parser.
// ----------------------------------------------------------------------------
`default_nettype none

package umhp_pkg;

    // message store capacity, default for the top level parameter
    localparam int MSG_DEPTH_DEF = 128;

    // result queue behind the read-port stage
    localparam int FIFO_DEPTH = 4;

    // transaction kinds
    localparam logic [1:0] KIND_BYTE    = 2'd0;
    localparam logic [1:0] KIND_READ    = 2'd1;
    localparam logic [1:0] KIND_RELEASE = 2'd2;

    // parser phases
    localparam logic [1:0] PH_SEARCH  = 2'd0;
    localparam logic [1:0] PH_LENGTH  = 2'd1;
    localparam logic [1:0] PH_CAPTURE = 2'd2;

    // "IPD," packed as it shifts in, then the length terminator and digit base
    localparam logic [31:0] HEADER_WORD = 32'h4950_442C;
    localparam logic [7:0]  COLON_CHAR  = 8'h3A;
    localparam logic [7:0]  ZERO_CHAR   = 8'h30;
    localparam logic [7:0]  NINE_CHAR   = 8'h39;

    typedef struct packed {
        logic       ready_res;
        logic [7:0] message_length;
        logic       length_error;
    } status_t;

    typedef struct packed {
        status_t    status;
        logic [7:0] read_byte;
    } result_t;

endpackage

`default_nettype wire

// ===== design/umhp_ram.sv =====
// ----------------------------------------------------------------------------
// umhp_ram
// Generic single write port, single read port RAM with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module umhp_ram #(
    parameter  int WIDTH = 8,
    parameter  int DEPTH = 128,
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             clk,
    input  wire logic             we,
    input  wire logic [AW-1:0]    waddr,
    input  wire logic [WIDTH-1:0] wdata,
    input  wire logic             re,
    input  wire logic [AW-1:0]    raddr,
    output logic      [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

// ===== design/umhp_ctrl.sv =====
// ----------------------------------------------------------------------------
// umhp_ctrl
// Header search, length accumulation and capture control. Issues store
// writes and reads and presents the status that follows each transaction.
// ----------------------------------------------------------------------------
`default_nettype none

module umhp_ctrl #(
    parameter  int MSG_DEPTH = umhp_pkg::MSG_DEPTH_DEF,
    localparam int AW        = (MSG_DEPTH > 1) ? $clog2(MSG_DEPTH) : 1
) (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              accept,
    input  wire logic [1:0]        kind,
    input  wire logic [7:0]        data_byte,
    input  wire logic [6:0]        read_index,
    output logic                   wr_en,
    output logic      [AW-1:0]     wr_addr,
    output logic      [7:0]        wr_data,
    output logic                   rd_en,
    output logic      [AW-1:0]     rd_addr,
    output umhp_pkg::status_t      status_next
);

    localparam logic [7:0]  DEPTH_B = 8'(MSG_DEPTH);
    localparam logic [11:0] DEPTH_W = 12'(MSG_DEPTH);

    logic [31:0] window_reg, window_next;
    logic [1:0]  phase_reg, phase_next;
    logic [7:0]  remain_reg, remain_next;
    logic [7:0]  wpos_reg, wpos_next;
    logic        held_reg, held_next;
    logic        error_reg, error_next;

    logic [31:0] window_shift;
    logic        is_digit;
    logic [11:0] acc;
    logic        wpos_room;
    logic [7:0]  remain_dec;
    logic [7:0]  wpos_inc;
    logic [7:0]  index_ext;
    logic        read_hit;

    assign window_shift = {window_reg[23:0], data_byte};
    assign is_digit     = (data_byte >= umhp_pkg::ZERO_CHAR) && (data_byte <= umhp_pkg::NINE_CHAR);
    // ascii digits keep their value in the low nibble
    assign acc          = ({4'd0, remain_reg} * 12'd10) + {8'd0, data_byte[3:0]};
    assign wpos_room    = wpos_reg < DEPTH_B;
    assign remain_dec   = remain_reg - {7'd0, (remain_reg != 8'd0)};
    assign wpos_inc     = wpos_reg + {7'd0, wpos_room};
    assign index_ext    = {1'b0, read_index};
    assign read_hit     = index_ext < DEPTH_B;

    always_comb
    begin
        window_next = window_reg;
        phase_next  = phase_reg;
        remain_next = remain_reg;
        wpos_next   = wpos_reg;
        held_next   = held_reg;
        error_next  = error_reg;
        if (accept)
        begin
            case (kind)
                umhp_pkg::KIND_BYTE:
                begin
                    if (!held_reg)
                    begin
                        case (phase_reg)
                            umhp_pkg::PH_LENGTH:
                            begin
                                if (data_byte == umhp_pkg::COLON_CHAR)
                                begin
                                    if ((remain_reg == 8'd0) || (remain_reg > DEPTH_B))
                                    begin
                                        error_next  = 1'b1;
                                        window_next = '0;
                                        phase_next  = umhp_pkg::PH_SEARCH;
                                        remain_next = '0;
                                    end
                                    else
                                    begin
                                        window_next = '0;
                                        wpos_next   = '0;
                                        phase_next  = umhp_pkg::PH_CAPTURE;
                                    end
                                end
                                else if (is_digit)
                                begin
                                    if (acc > DEPTH_W)
                                    begin
                                        error_next  = 1'b1;
                                        window_next = '0;
                                        phase_next  = umhp_pkg::PH_SEARCH;
                                        remain_next = '0;
                                    end
                                    else
                                    begin
                                        remain_next = acc[7:0];
                                    end
                                end
                                else
                                begin
                                    // stray character drops the length quietly
                                    window_next = '0;
                                    phase_next  = umhp_pkg::PH_SEARCH;
                                    remain_next = '0;
                                end
                            end
                            umhp_pkg::PH_CAPTURE:
                            begin
                                wpos_next   = wpos_inc;
                                remain_next = remain_dec;
                                if ((remain_dec == 8'd0) || (wpos_inc >= DEPTH_B))
                                begin
                                    remain_next = '0;
                                    held_next   = 1'b1;
                                end
                            end
                            default:
                            begin
                                window_next = window_shift;
                                if (window_shift == umhp_pkg::HEADER_WORD)
                                begin
                                    phase_next  = umhp_pkg::PH_LENGTH;
                                    remain_next = '0;
                                end
                            end
                        endcase
                    end
                end
                umhp_pkg::KIND_RELEASE:
                begin
                    held_next   = 1'b0;
                    wpos_next   = '0;
                    window_next = '0;
                    phase_next  = umhp_pkg::PH_SEARCH;
                    remain_next = '0;
                end
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            window_reg <= '0;
            phase_reg  <= umhp_pkg::PH_SEARCH;
            remain_reg <= '0;
            wpos_reg   <= '0;
            held_reg   <= 1'b0;
            error_reg  <= 1'b0;
        end
        else
        begin
            window_reg <= window_next;
            phase_reg  <= phase_next;
            remain_reg <= remain_next;
            wpos_reg   <= wpos_next;
            held_reg   <= held_next;
            error_reg  <= error_next;
        end
    end

    assign wr_en   = accept && (kind == umhp_pkg::KIND_BYTE) && !held_reg
                     && (phase_reg == umhp_pkg::PH_CAPTURE) && wpos_room;
    assign wr_addr = wpos_reg[AW-1:0];
    assign wr_data = data_byte;

    assign rd_en   = accept && (kind == umhp_pkg::KIND_READ) && read_hit;
    assign rd_addr = index_ext[AW-1:0];

    assign status_next.ready_res      = held_next;
    assign status_next.message_length = wpos_next;
    assign status_next.length_error   = error_next;

endmodule

`default_nettype wire

// ===== design/udp_message_header_parser_core.sv =====
// ----------------------------------------------------------------------------
// udp_message_header_parser_core
// Finds "IPD,<len>:" in a received byte stream and captures the payload.
// ----------------------------------------------------------------------------
// One transaction is taken every cycle while in_stall is low. Each one gives
// exactly one result: the parser state updates and the message store read is
// issued in the accept cycle, the RAM read port and the read stage register the
// data and status, and the result then enters a four-entry queue, from which it
// can leave. The queue lets the input keep flowing while a result waits at the
// output; in_stall rises once the queued results plus the transaction in the
// read stage reach four.
`default_nettype none

module udp_message_header_parser_core #(
    parameter int MSG_DEPTH = umhp_pkg::MSG_DEPTH_DEF
) (
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       in_valid,
    output logic            in_stall,
    input  wire logic [1:0] kind,
    input  wire logic [7:0] data_byte,
    input  wire logic [6:0] read_index,
    output logic            out_valid,
    input  wire logic       out_stall,
    output logic            ready_res,
    output logic      [7:0] read_byte,
    output logic      [7:0] message_length,
    output logic            length_error
);

    localparam int AW = (MSG_DEPTH > 1) ? $clog2(MSG_DEPTH) : 1;
    localparam int PW = $clog2(umhp_pkg::FIFO_DEPTH);
    localparam int CW = PW + 1;
    localparam logic [CW-1:0] FIFO_FULL = CW'(umhp_pkg::FIFO_DEPTH);

    logic               in_accept;
    logic               out_accept;
    logic               wr_en;
    logic [AW-1:0]      wr_addr;
    logic [7:0]         wr_data;
    logic               rd_en;
    logic [AW-1:0]      rd_addr;
    logic [7:0]         ram_q;
    umhp_pkg::status_t  status_next;

    logic               a_valid_reg;
    umhp_pkg::status_t  a_status_reg;
    logic               a_rd_reg;
    umhp_pkg::result_t  push_entry;

    umhp_pkg::result_t  fifo_reg [umhp_pkg::FIFO_DEPTH];
    logic [PW-1:0]      wr_ptr_reg;
    logic [PW-1:0]      rd_ptr_reg;
    logic [CW-1:0]      count_reg;
    logic [CW-1:0]      count_next;
    logic [CW-1:0]      in_flight;
    umhp_pkg::result_t  head;

    assign in_accept  = in_valid && !in_stall;
    assign out_accept = out_valid && !out_stall;

    umhp_ctrl #(
        .MSG_DEPTH (MSG_DEPTH)
    ) u_ctrl (
        .clk         (clk),
        .rst_n       (rst_n),
        .accept      (in_accept),
        .kind        (kind),
        .data_byte   (data_byte),
        .read_index  (read_index),
        .wr_en       (wr_en),
        .wr_addr     (wr_addr),
        .wr_data     (wr_data),
        .rd_en       (rd_en),
        .rd_addr     (rd_addr),
        .status_next (status_next)
    );

    umhp_ram #(
        .WIDTH (8),
        .DEPTH (MSG_DEPTH)
    ) u_store (
        .clk   (clk),
        .we    (wr_en),
        .waddr (wr_addr),
        .wdata (wr_data),
        .re    (rd_en),
        .raddr (rd_addr),
        .rdata (ram_q)
    );

    // read stage: status waits here while the store read completes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg <= 1'b0;
        end
        else
        begin
            a_valid_reg <= in_accept;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            a_status_reg <= status_next;
            a_rd_reg     <= rd_en;
        end
    end

    assign push_entry.status    = a_status_reg;
    assign push_entry.read_byte = a_rd_reg ? ram_q : 8'd0;

    // result queue
    always_ff @(posedge clk)
    begin
        if (a_valid_reg)
        begin
            fifo_reg[wr_ptr_reg] <= push_entry;
        end
    end

    always_comb
    begin
        count_next = count_reg;
        if (a_valid_reg && !out_accept)
        begin
            count_next = count_reg + CW'(1);
        end
        else if (!a_valid_reg && out_accept)
        begin
            count_next = count_reg - CW'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (a_valid_reg)
            begin
                wr_ptr_reg <= wr_ptr_reg + PW'(1);
            end
            if (out_accept)
            begin
                rd_ptr_reg <= rd_ptr_reg + PW'(1);
            end
            count_reg <= count_next;
        end
    end

    // the transaction in the read stage already owns a queue slot
    assign in_flight = count_reg + {{(CW-1){1'b0}}, a_valid_reg};
    assign in_stall  = in_flight >= FIFO_FULL;

    assign head           = fifo_reg[rd_ptr_reg];
    assign out_valid      = count_reg != '0;
    assign ready_res      = head.status.ready_res;
    assign read_byte      = head.read_byte;
    assign message_length = head.status.message_length;
    assign length_error   = head.status.length_error;

    // queue never holds more than its depth
    assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= FIFO_FULL)
        else $error("result queue overflow");

    // captured length stays within the store
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (message_length <= 8'(MSG_DEPTH)))
        else $error("message length beyond store depth");

    // a held message always has at least one byte
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && ready_res) |-> (message_length != 8'd0))
        else $error("held message with no payload");

    // release clears the hold and the length
    assert property (@(posedge clk) disable iff (!rst_n)
        (in_accept && (kind == umhp_pkg::KIND_RELEASE))
        |=> (!a_status_reg.ready_res && (a_status_reg.message_length == 8'd0)))
        else $error("release did not clear message");

endmodule

`default_nettype wire

// ===== tb/udp_message_header_parser_core_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// udp_message_header_parser_core_tb
// Streams modem bytes, store reads and releases through the parser and checks
// every status transaction against a cycle-free model of the header search,
// length accumulation and payload capture, under random stalls on both sides.
// ----------------------------------------------------------------------------

module udp_message_header_parser_core_tb;

    localparam int MSG_DEPTH = umhp_pkg::MSG_DEPTH_DEF;
    localparam int QUIET_LIMIT = 4000;
    localparam int LONG_HOLD = 80;
    localparam logic [1:0] KIND_UNUSED = 2'd3;

    typedef struct packed {
        logic [1:0] kind;
        logic [7:0] data;
        logic [6:0] idx;
    } modem_item_t;

    typedef struct packed {
        logic [31:0]               window;
        logic [1:0]                phase;
        logic [7:0]                due;
        logic [7:0]                wpos;
        logic                      held;
        logic                      err;
        logic [MSG_DEPTH-1:0][7:0] store;
    } parser_model_t;

    logic       clk;
    logic       rst_n = 1'b0;
    logic       in_valid = 1'b0;
    logic       in_stall;
    logic [1:0] kind = umhp_pkg::KIND_BYTE;
    logic [7:0] data_byte = 8'h00;
    logic [6:0] read_index = 7'h00;
    logic       out_valid;
    logic       out_stall = 1'b0;
    logic       ready_res;
    logic [7:0] read_byte;
    logic [7:0] message_length;
    logic       length_error;

    modem_item_t       outgoing_q[$];
    umhp_pkg::result_t due_results[$];
    parser_model_t     plan_st;
    parser_model_t     live_st;
    int                hiwater = 0;
    int                n_items = 0;
    int                fails = 0;
    int                quiet = 0;
    int                src_gap = 0;
    int                sink_gap = 0;
    int                hold_left = 0;
    int                hold_req = 0;
    int                hold_ack = 0;
    logic              idle_on = 1'b1;
    logic              in_fire = 1'b0;

    udp_message_header_parser_core #(
        .MSG_DEPTH(MSG_DEPTH)
    ) dut (
        .clk(clk),
        .rst_n(rst_n),
        .in_valid(in_valid),
        .in_stall(in_stall),
        .kind(kind),
        .data_byte(data_byte),
        .read_index(read_index),
        .out_valid(out_valid),
        .out_stall(out_stall),
        .ready_res(ready_res),
        .read_byte(read_byte),
        .message_length(message_length),
        .length_error(length_error)
    );

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    function automatic parser_model_t to_search(parser_model_t s);
        s.window = '0;
        s.phase = umhp_pkg::PH_SEARCH;
        s.due = '0;
        return s;
    endfunction

    function automatic parser_model_t parse_item(input parser_model_t s, input logic [1:0] k,
                                                 input logic [7:0] c, input logic [6:0] idx,
                                                 output umhp_pkg::result_t r);
        int v;
        r = '0;
        if (k == umhp_pkg::KIND_BYTE && !s.held)
        begin
            if (s.phase == umhp_pkg::PH_LENGTH)
            begin
                if (c == umhp_pkg::COLON_CHAR)
                begin
                    if (s.due == 0 || s.due > MSG_DEPTH)
                    begin
                        s.err = 1'b1;
                        s = to_search(s);
                    end
                    else
                    begin
                        s.window = '0;
                        s.wpos = '0;
                        s.phase = umhp_pkg::PH_CAPTURE;
                    end
                end
                else if (c >= umhp_pkg::ZERO_CHAR && c <= umhp_pkg::NINE_CHAR)
                begin
                    v = int'(s.due) * 10 + int'(c) - int'(umhp_pkg::ZERO_CHAR);
                    if (v > MSG_DEPTH)
                    begin
                        s.err = 1'b1;
                        s = to_search(s);
                    end
                    else
                        s.due = v[7:0];
                end
                else
                    s = to_search(s);
            end
            else if (s.phase == umhp_pkg::PH_CAPTURE)
            begin
                if (s.wpos < MSG_DEPTH)
                begin
                    s.store[s.wpos] = c;
                    s.wpos = s.wpos + 8'd1;
                end
                if (s.due != 0)
                    s.due = s.due - 8'd1;
                if (s.due == 0 || s.wpos >= MSG_DEPTH)
                begin
                    s.due = '0;
                    s.held = 1'b1;
                end
            end
            else
            begin
                s.window = {s.window[23:0], c};
                if (s.window == umhp_pkg::HEADER_WORD)
                begin
                    s.phase = umhp_pkg::PH_LENGTH;
                    s.due = '0;
                end
            end
        end
        else if (k == umhp_pkg::KIND_READ)
        begin
            if (idx < MSG_DEPTH)
                r.read_byte = s.store[idx];
        end
        else if (k == umhp_pkg::KIND_RELEASE)
        begin
            s.held = 1'b0;
            s.wpos = '0;
            s = to_search(s);
        end
        r.status.ready_res = s.held;
        r.status.message_length = s.wpos;
        r.status.length_error = s.err;
        return s;
    endfunction

    // ---------------- stimulus planning ----------------

    task automatic offer(input logic [1:0] k, input logic [7:0] c, input logic [6:0] idx);
        umhp_pkg::result_t unused;
        modem_item_t       it;
        // bytes swallowed while a message is held, and the unused kind, do not count
        if (k != KIND_UNUSED && !(k == umhp_pkg::KIND_BYTE && plan_st.held))
            n_items++;
        plan_st = parse_item(plan_st, k, c, idx, unused);
        if (plan_st.wpos > hiwater)
            hiwater = plan_st.wpos;
        it.kind = k;
        it.data = c;
        it.idx = idx;
        outgoing_q.push_back(it);
    endtask

    task automatic offer_byte(input logic [7:0] c);
        offer(umhp_pkg::KIND_BYTE, c, 7'($urandom));
    endtask

    // only positions written since reset are ever read
    task automatic offer_read();
        if (hiwater != 0)
            offer(umhp_pkg::KIND_READ, 8'($urandom), 7'($urandom_range(0, hiwater - 1)));
    endtask

    task automatic offer_text(input string s);
        for (int i = 0; i < s.len(); i++)
            offer_byte(s[i]);
    endtask

    task automatic offer_message();
        int sel;
        int len;
        sel = $urandom_range(0, 99);
        if (sel < 4)
            len = MSG_DEPTH;
        else if (sel < 9)
            len = $urandom_range(13, MSG_DEPTH - 1);
        else if (sel < 12)
            len = 0;
        else if (sel < 15)
            len = $urandom_range(MSG_DEPTH + 1, 999);
        else
            len = $urandom_range(1, 12);
        repeat ($urandom_range(0, 2))
            offer_byte(8'($urandom));
        offer_text("IPD,");
        if ($urandom_range(0, 7) == 0)
            offer_byte(umhp_pkg::ZERO_CHAR);
        if (len != 0 || $urandom_range(0, 1) == 0)
            offer_text($sformatf("%0d", len));
        offer_byte(umhp_pkg::COLON_CHAR);
        if (len >= 1 && len <= MSG_DEPTH)
        begin
            for (int i = 0; i < len; i++)
            begin
                offer_byte(8'($urandom));
                if ($urandom_range(0, 9) == 0)
                    offer_read();
            end
            repeat ($urandom_range(0, 2))
                offer_byte(8'($urandom));
        end
        repeat ($urandom_range(0, 4))
            offer_read();
        offer(umhp_pkg::KIND_RELEASE, 8'($urandom), 7'($urandom));
        if ($urandom_range(0, 3) == 0)
            offer_read();
    endtask

    task automatic offer_noise();
        logic [7:0] c;
        case ($urandom_range(0, 2))
            0:
            begin
                repeat ($urandom_range(1, 8))
                begin
                    case ($urandom_range(0, 3))
                        0: offer_read();
                        1: offer(umhp_pkg::KIND_RELEASE, 8'($urandom), 7'($urandom));
                        2: offer(KIND_UNUSED, 8'($urandom), 7'($urandom));
                        default: offer_byte(8'($urandom));
                    endcase
                end
            end
            1:
            begin
                offer_text("IP");
                offer_byte(8'($urandom));
            end
            default:
            begin
                // length cut short by a stray character
                offer_text("IPD,");
                offer_text($sformatf("%0d", $urandom_range(0, 99)));
                c = 8'($urandom);
                if ((c >= umhp_pkg::ZERO_CHAR && c <= umhp_pkg::NINE_CHAR)
                    || c == umhp_pkg::COLON_CHAR)
                    c = 8'h78;
                offer_byte(c);
            end
        endcase
        if ($urandom_range(0, 1) == 0)
            offer(umhp_pkg::KIND_RELEASE, 8'($urandom), 7'($urandom));
    endtask

    // ---------------- driver ----------------

    always @(negedge clk)
    begin
        modem_item_t nxt;
        if (!rst_n)
            in_valid <= 1'b0;
        else if (!in_valid || in_fire)
        begin
            if (src_gap != 0)
            begin
                src_gap <= src_gap - 1;
                in_valid <= 1'b0;
            end
            else if (outgoing_q.size() != 0)
            begin
                nxt = outgoing_q.pop_front();
                kind <= nxt.kind;
                data_byte <= nxt.data;
                read_index <= nxt.idx;
                in_valid <= 1'b1;
                if (idle_on && $urandom_range(0, 9) == 0)
                    src_gap <= $urandom_range(1, 6);
            end
            else
                in_valid <= 1'b0;
        end
    end

    // ---------------- receiver stall ----------------

    always @(negedge clk)
    begin
        if (!rst_n)
            out_stall <= 1'b0;
        else if (hold_left != 0)
        begin
            out_stall <= 1'b1;
            hold_left <= hold_left - 1;
        end
        else if (hold_req != hold_ack)
        begin
            hold_ack <= hold_req;
            hold_left <= LONG_HOLD;
            out_stall <= 1'b1;
        end
        else if (sink_gap != 0)
        begin
            out_stall <= 1'b1;
            sink_gap <= sink_gap - 1;
        end
        else if (idle_on && $urandom_range(0, 9) == 0)
        begin
            out_stall <= 1'b1;
            sink_gap <= $urandom_range(0, 5);
        end
        else
            out_stall <= 1'b0;
    end

    // ---------------- input transaction capture and prediction ----------------

    always @(posedge clk)
    begin
        umhp_pkg::result_t want;
        in_fire <= rst_n && in_valid && !in_stall;
        if (rst_n && in_valid && !in_stall)
        begin
            live_st = parse_item(live_st, kind, data_byte, read_index, want);
            due_results.push_back(want);
        end
    end

    // ---------------- output monitor ----------------

    always @(posedge clk)
    begin
        umhp_pkg::result_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (due_results.size() == 0)
            begin
                $error("result transaction with nothing expected");
                fails++;
            end
            else
            begin
                want = due_results.pop_front();
                if (ready_res !== want.status.ready_res)
                begin
                    $error("ready_res: expected %0d, got %0d", want.status.ready_res, ready_res);
                    fails++;
                end
                if (read_byte !== want.read_byte)
                begin
                    $error("read_byte: expected %0d, got %0d", want.read_byte, read_byte);
                    fails++;
                end
                if (message_length !== want.status.message_length)
                begin
                    $error("message_length: expected %0d, got %0d",
                           want.status.message_length, message_length);
                    fails++;
                end
                if (length_error !== want.status.length_error)
                begin
                    $error("length_error: expected %0d, got %0d",
                           want.status.length_error, length_error);
                    fails++;
                end
            end
        end
    end

    // ---------------- watchdog ----------------

    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall))
            quiet <= 0;
        else if (quiet >= QUIET_LIMIT)
        begin
            $display("TB_ERROR");
            $finish;
        end
        else
            quiet <= quiet + 1;
    end

    // ---------------- main sequence ----------------

    initial
    begin
        logic long_hold_done;
        logic drain_done;
        long_hold_done = 1'b0;
        drain_done = 1'b0;
        plan_st = '0;
        live_st = '0;

        rst_n = 1'b0;
        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // directed: unused kind, zero length, stray character, oversize length,
        // a short message with extreme bytes, a byte while held, reads and release
        offer(KIND_UNUSED, 8'hFF, 7'h7F);
        offer_text("IPD,:");
        offer_text("IPD,7x");
        offer_text("IPD,129");
        offer_text("IPD,2:");
        offer_byte(8'h00);
        offer_byte(8'hFF);
        offer_byte(8'h55);
        offer(umhp_pkg::KIND_READ, 8'h00, 7'd0);
        offer(umhp_pkg::KIND_READ, 8'hFF, 7'd1);
        offer(umhp_pkg::KIND_RELEASE, 8'h00, 7'h7F);

        while (n_items < 2000)
        begin
            if ($urandom_range(0, 4) == 0)
                offer_noise();
            else
                offer_message();
            while (outgoing_q.size() > 64)
                @(posedge clk);
            if (!long_hold_done && n_items > 500)
            begin
                // receiver holds off while the sender keeps a full queue offered
                hold_req++;
                long_hold_done = 1'b1;
            end
            if (!drain_done && n_items > 1000)
            begin
                while (outgoing_q.size() != 0 || in_valid || due_results.size() != 0)
                    @(posedge clk);
                drain_done = 1'b1;
            end
            if (n_items > 1700)
                idle_on = 1'b0;
        end

        while (outgoing_q.size() != 0 || in_valid)
            @(posedge clk);
        while (due_results.size() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);
        if (due_results.size() != 0)
            fails++;

        if (fails == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule
